FILE: hw/rtl/rtc_s2c_pkg.sv
// package with control word format, microcode rom and calendar constants
package rtc_s2c_pkg;

    localparam logic [31:0] EPOCH_OFFSET = 32'd946684800;
    localparam logic [31:0] DAY_SECONDS  = 32'd86400;
    localparam logic [31:0] MIN_SECONDS  = 32'd60;
    localparam logic [11:0] BASE_YEAR    = 12'd1970;
    localparam logic [8:0]  YEAR_DAYS    = 9'd365;
    localparam logic [15:0] FEB29_DAY    = 16'd59;
    localparam logic [3:0]  LAST_MONTH   = 4'd11;
    localparam logic [1:0]  BASE_MOD4    = 2'd2;
    localparam logic [6:0]  BASE_MOD100  = 7'd70;
    localparam logic [8:0]  BASE_MOD400  = 9'd370;
    localparam logic [6:0]  LAST_MOD100  = 7'd99;
    localparam logic [8:0]  LAST_MOD400  = 9'd399;

    // reciprocals: (x >> 7) / 675 over 2^35, (x >> 2) / 15 over 2^19 and over 2^13
    localparam logic [25:0] DAY_RECIP    = 26'd50903317;
    localparam logic [15:0] MIN_RECIP    = 16'd34953;
    localparam logic [9:0]  HOUR_RECIP   = 10'd547;

    typedef logic [3:0] op_t;
    typedef logic [2:0] cond_t;
    typedef logic [3:0] pc_t;

    localparam op_t OP_NONE    = 4'd0;
    localparam op_t OP_LOAD    = 4'd1;
    localparam op_t OP_DIV_DAY = 4'd2;
    localparam op_t OP_SET_MIN = 4'd3;
    localparam op_t OP_SET_HR  = 4'd4;
    localparam op_t OP_SPLIT   = 4'd5;
    localparam op_t OP_YEAR    = 4'd6;
    localparam op_t OP_LEAPFIX = 4'd7;
    localparam op_t OP_MONTH   = 4'd8;
    localparam op_t OP_EMIT    = 4'd9;
    localparam op_t OP_DIV_MIN = 4'd10;
    localparam op_t OP_DIV_HR  = 4'd11;

    localparam cond_t C_NEVER    = 3'd0;
    localparam cond_t C_ALWAYS   = 3'd1;
    localparam cond_t C_NO_INPUT = 3'd2;
    localparam cond_t C_YEAR_GE  = 3'd3;
    localparam cond_t C_MONTH_GE = 3'd4;
    localparam cond_t C_OUT_BUSY = 3'd5;

    localparam pc_t PC_IDLE    = 4'd0;
    localparam pc_t PC_DIV_DAY = 4'd1;
    localparam pc_t PC_SET_MIN = 4'd2;
    localparam pc_t PC_DIV_MIN = 4'd3;
    localparam pc_t PC_SET_HR  = 4'd4;
    localparam pc_t PC_DIV_HR  = 4'd5;
    localparam pc_t PC_SPLIT   = 4'd6;
    localparam pc_t PC_YEAR    = 4'd7;
    localparam pc_t PC_LEAPFIX = 4'd8;
    localparam pc_t PC_MONTH   = 4'd9;
    localparam pc_t PC_EMIT    = 4'd10;
    localparam pc_t PC_RETURN  = 4'd11;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_word_t;

    function automatic ctrl_word_t rom_word(input pc_t pc);
        ctrl_word_t w;
        unique case (pc)
            PC_IDLE:    w = '{op: OP_LOAD,    cond: C_NO_INPUT, target: PC_IDLE};
            PC_DIV_DAY: w = '{op: OP_DIV_DAY, cond: C_NEVER,    target: PC_IDLE};
            PC_SET_MIN: w = '{op: OP_SET_MIN, cond: C_NEVER,    target: PC_IDLE};
            PC_DIV_MIN: w = '{op: OP_DIV_MIN, cond: C_NEVER,    target: PC_IDLE};
            PC_SET_HR:  w = '{op: OP_SET_HR,  cond: C_NEVER,    target: PC_IDLE};
            PC_DIV_HR:  w = '{op: OP_DIV_HR,  cond: C_NEVER,    target: PC_IDLE};
            PC_SPLIT:   w = '{op: OP_SPLIT,   cond: C_NEVER,    target: PC_IDLE};
            PC_YEAR:    w = '{op: OP_YEAR,    cond: C_YEAR_GE,  target: PC_YEAR};
            PC_LEAPFIX: w = '{op: OP_LEAPFIX, cond: C_NEVER,    target: PC_IDLE};
            PC_MONTH:   w = '{op: OP_MONTH,   cond: C_MONTH_GE, target: PC_MONTH};
            PC_EMIT:    w = '{op: OP_EMIT,    cond: C_OUT_BUSY, target: PC_EMIT};
            PC_RETURN:  w = '{op: OP_NONE,    cond: C_ALWAYS,   target: PC_IDLE};
            default:    w = '{op: OP_NONE,    cond: C_ALWAYS,   target: PC_IDLE};
        endcase
        return w;
    endfunction

    // days in months january through november
    function automatic logic [4:0] month_len(input logic [3:0] mon);
        logic [4:0] len;
        unique case (mon)
            4'd1:                      len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: hw/rtl/rtc_seconds_to_calendar.sv
// rtc seconds count to calendar date and time, microcoded sequencer
//
// usage:
//   cfg_valid/cfg_ready/cfg_data writes the 32-bit bias; cfg_ready is always high.
//   s_tvalid/s_tready/s_tdata carries one raw 32-bit seconds count (since 2000).
//   m_tvalid/m_tready/m_tdata returns second, minute, hour, day, month, year.
// sequence: after an input transfer, six fixed steps split the day, minute
//   and hour by reciprocal multiplies; the year loop then takes off one year
//   per pass for each whole year past 1970 (0..136), a leap fix step follows,
//   and the month loop takes off one month per pass up to the zero-based month (0..11).
// flow: one item at a time; s_tready is high only while the step counter
//   sits at the idle step, so no new count is taken until the last result is emitted.
// reset: aresetn synchronous active low; bias clears to zero, the step
//   counter returns to idle and m_tvalid drops.
// stall: a result waits in the output register while m_tready is low; the
//   next result holds at the emit step until that register is taken.
module rtc_seconds_to_calendar (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,   // rtc_bias
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // raw_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // second, minute, hour, day, month, year, zero pad
);
    import rtc_s2c_pkg::*;

    pc_t        pc_reg, pc_next;
    ctrl_word_t cw;
    logic       taken;

    logic [31:0] bias_reg;
    logic [31:0] acc_reg;
    logic [15:0] quo_reg;
    logic [15:0] days_reg;
    logic [11:0] year_reg;
    logic [1:0]  y4_reg;
    logic [6:0]  y100_reg;
    logic [8:0]  y400_reg;
    logic [3:0]  mon_reg;
    logic [4:0]  day_reg;
    logic [5:0]  sec_reg;
    logic [5:0]  min_reg;
    logic [4:0]  hour_reg;
    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    logic [50:0] day_prod;
    logic [30:0] min_prod;
    logic [18:0] hour_prod;
    logic [31:0] day_rem;
    logic [31:0] part_rem;
    logic        leap;
    logic [8:0]  year_len;
    logic        year_ge;
    logic [4:0]  mlen;
    logic        month_ge;
    logic        out_free;
    logic [31:0] biased;

    assign cw        = rom_word(pc_reg);
    assign day_prod  = {26'd0, acc_reg[31:7]} * {25'd0, DAY_RECIP};
    assign min_prod  = {16'd0, acc_reg[16:2]} * {15'd0, MIN_RECIP};
    assign hour_prod = {10'd0, acc_reg[10:2]} * {9'd0, HOUR_RECIP};
    assign day_rem   = acc_reg - {16'd0, days_reg} * DAY_SECONDS;
    assign part_rem  = acc_reg - {16'd0, quo_reg} * MIN_SECONDS;
    assign leap     = ((y4_reg == 2'd0) && (y100_reg != 7'd0)) || (y400_reg == 9'd0);
    assign year_len = YEAR_DAYS + {8'd0, leap};
    assign year_ge  = days_reg >= {7'd0, year_len};
    assign mlen     = month_len(mon_reg);
    assign month_ge = (mon_reg < LAST_MONTH) && (days_reg >= {11'd0, mlen});
    assign out_free = !m_tvalid_reg || m_tready;
    assign biased   = (s_tdata == 32'd0) ? 32'd0 : s_tdata + bias_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = (pc_reg == PC_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        unique case (cw.cond)
            C_NEVER:    taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_NO_INPUT: taken = !s_tvalid;
            C_YEAR_GE:  taken = year_ge;
            C_MONTH_GE: taken = month_ge;
            C_OUT_BUSY: taken = !out_free;
            default:    taken = 1'b1;
        endcase
        pc_next = taken ? cw.target : pc_reg + 4'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= PC_IDLE;
            bias_reg     <= 32'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pc_reg <= pc_next;
            if (cfg_valid) begin
                bias_reg <= cfg_data;
            end
            if (cw.op == OP_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cw.op)
            OP_LOAD: begin
                if (s_tvalid) begin
                    acc_reg <= biased + EPOCH_OFFSET;
                end
            end
            OP_DIV_DAY: begin
                days_reg <= day_prod[50:35];
            end
            OP_SET_MIN: begin
                acc_reg <= day_rem;
            end
            OP_DIV_MIN: begin
                quo_reg <= {5'd0, min_prod[29:19]};
            end
            OP_SET_HR: begin
                sec_reg <= part_rem[5:0];
                acc_reg <= {16'd0, quo_reg};
            end
            OP_DIV_HR: begin
                quo_reg <= {11'd0, hour_prod[17:13]};
            end
            OP_SPLIT: begin
                min_reg  <= part_rem[5:0];
                hour_reg <= quo_reg[4:0];
                year_reg <= BASE_YEAR;
                y4_reg   <= BASE_MOD4;
                y100_reg <= BASE_MOD100;
                y400_reg <= BASE_MOD400;
            end
            OP_YEAR: begin
                if (year_ge) begin
                    days_reg <= days_reg - {7'd0, year_len};
                    year_reg <= year_reg + 12'd1;
                    y4_reg   <= y4_reg + 2'd1;
                    y100_reg <= (y100_reg == LAST_MOD100) ? 7'd0 : y100_reg + 7'd1;
                    y400_reg <= (y400_reg == LAST_MOD400) ? 9'd0 : y400_reg + 9'd1;
                end
            end
            OP_LEAPFIX: begin
                mon_reg <= 4'd0;
                if (leap && days_reg >= FEB29_DAY) begin
                    day_reg  <= (days_reg == FEB29_DAY) ? 5'd2 : 5'd1;
                    days_reg <= days_reg - 16'd1;
                end else begin
                    day_reg <= 5'd1;
                end
            end
            OP_MONTH: begin
                if (month_ge) begin
                    days_reg <= days_reg - {11'd0, mlen};
                    mon_reg  <= mon_reg + 4'd1;
                end
            end
            OP_EMIT: begin
                if (out_free) begin
                    m_tdata_reg <= {2'd0, year_reg, mon_reg + 4'd1,
                                    day_reg + days_reg[4:0], hour_reg, min_reg, sec_reg};
                end
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: hw/rtl/rtc_s2c_checker.sv
// port-level checker for the rtc seconds to calendar block, with its bind
module rtc_s2c_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in flight: busy right after an input transfer
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again while busy");

    // reset empties the output
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // every result has seconds, minutes, hours, month and year in range and a nonzero day
    a_fields_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] < 6'd60) && (m_tdata[11:6] < 6'd60)
            && (m_tdata[16:12] < 5'd24) && (m_tdata[21:17] != 5'd0)
            && (m_tdata[25:22] != 4'd0) && (m_tdata[25:22] < 4'd13)
            && (m_tdata[37:26] >= 12'd1970) && (m_tdata[37:26] <= 12'd2106))
        else $error("result field out of range");

endmodule

bind rtc_seconds_to_calendar rtc_s2c_checker u_rtc_s2c_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
